// ===== src/ccmf_pkg.sv =====
// Shared types and constants for the CCM header formatter.
`timescale 1ns / 1ps
package ccmf_pkg;

    localparam int DEF_AAD_COUNT_BITS = 32;
    localparam int MAX_BYTES          = 16;

    localparam logic [1:0] CFG_NONCE_LEN   = 2'd0;
    localparam logic [1:0] CFG_AAD_LEN     = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd2;
    localparam logic [1:0] CFG_TAG_LEN     = 2'd3;

    localparam logic [3:0]  NONCE_MIN     = 4'd7;
    localparam logic [3:0]  NONCE_MAX     = 4'd13;
    localparam logic [3:0]  LEN_FIELD_SUM = 4'd15;
    localparam logic [7:0]  AAD_MARK_HI   = 8'hFF;
    localparam logic [7:0]  AAD_MARK_LO   = 8'hFE;
    localparam logic [31:0] AAD_LONG_MIN  = 32'h0000_FF00;
    localparam logic [3:0]  PFX_SHORT     = 4'd2;
    localparam logic [3:0]  PFX_LONG      = 4'd6;

    typedef enum logic [1:0] {
        PH_NONCE,
        PH_AAD,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [3:0]  nonce_len;
        logic [31:0] aad_len;
        logic [31:0] payload_len;
        logic [4:0]  tag_len;
    } t_cfg;

    // Result bytes for one request plus the flags that apply to them.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [4:0]                count;
        logic                      stream_end;
        logic                      bad;
    } t_plan;

endpackage

// ===== src/ccmf_sched.sv =====
// Stream state and per-request result planning for the CCM header formatter.
`timescale 1ns / 1ps
module ccmf_sched import ccmf_pkg::*; #(
    parameter int AAD_COUNT_BITS = DEF_AAD_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_data_byte,
    input  logic       i_take,
    output t_plan      o_plan
);

    t_phase                    r_phase,       n_phase;
    logic [3:0]                r_nonce_count, n_nonce_count;
    logic [AAD_COUNT_BITS-1:0] r_aad_count,   n_aad_count;
    logic [3:0]                r_block_pos,   n_block_pos;

    logic [3:0]  lsz;
    logic        nonce_ok;
    logic        fits;
    logic        bad;
    logic        first;
    logic        nlast;
    logic        aad_nz;
    logic        pfx_long;
    logic [3:0]  plen;
    logic [2:0]  tf;
    logic [7:0]  flags;
    logic        alast;
    logic [32:0] aad_next_ext;

    assign lsz      = LEN_FIELD_SUM - i_cfg.nonce_len;
    assign nonce_ok = (i_cfg.nonce_len >= NONCE_MIN) && (i_cfg.nonce_len <= NONCE_MAX);
    always_comb begin
        case (lsz)
            4'd2:    fits = (i_cfg.payload_len[31:16] == 16'd0);
            4'd3:    fits = (i_cfg.payload_len[31:24] == 8'd0);
            default: fits = 1'b1;
        endcase
    end
    assign bad      = !(nonce_ok && fits);
    assign first    = (r_nonce_count == 4'd0);
    assign nlast    = ({1'b0, r_nonce_count} + 5'd1) >= {1'b0, i_cfg.nonce_len};
    assign aad_nz   = (i_cfg.aad_len != 32'd0);
    assign pfx_long = (i_cfg.aad_len >= AAD_LONG_MIN);
    assign plen     = aad_nz ? (pfx_long ? PFX_LONG : PFX_SHORT) : 4'd0;
    assign tf       = (i_cfg.tag_len < 5'd2) ? 3'd0 : (i_cfg.tag_len[3:1] - 3'd1);
    assign flags    = {1'b0, aad_nz, tf, lsz[2:0] - 3'd1};

    assign aad_next_ext = 33'(r_aad_count) + 33'd1;
    assign alast        = (aad_next_ext >= {1'b0, i_cfg.aad_len}) || (&r_aad_count);

    always_comb begin
        logic [3:0] jj;
        logic [3:0] off;
        logic [3:0] m;
        logic [3:0] k;
        logic [3:0] p;

        o_plan        = '0;
        n_phase       = r_phase;
        n_nonce_count = r_nonce_count;
        n_aad_count   = r_aad_count;
        n_block_pos   = r_block_pos;
        off           = first ? 4'd1 : 4'd0;
        m             = '0;
        k             = '0;
        p             = '0;
        jj            = '0;

        if (bad) begin
            o_plan.count = 5'd1;
            o_plan.bad   = 1'b1;
        end else begin
            case (r_phase)
                PH_NONCE: begin
                    for (int j = 0; j < MAX_BYTES; j++) begin
                        jj = 4'(j);
                        if (jj < off) begin
                            o_plan.bytes[j] = flags;
                        end else if (jj == off) begin
                            o_plan.bytes[j] = i_data_byte;
                        end else begin
                            m = jj - off - 4'd1;
                            if (m < lsz) begin
                                k = lsz - 4'd1 - m;
                                o_plan.bytes[j] = (k < 4'd4) ?
                                    i_cfg.payload_len[{k[1:0], 3'b000} +: 8] : 8'd0;
                            end else begin
                                p = m - lsz;
                                if (pfx_long) begin
                                    case (p)
                                        4'd0:    o_plan.bytes[j] = AAD_MARK_HI;
                                        4'd1:    o_plan.bytes[j] = AAD_MARK_LO;
                                        4'd2:    o_plan.bytes[j] = i_cfg.aad_len[31:24];
                                        4'd3:    o_plan.bytes[j] = i_cfg.aad_len[23:16];
                                        4'd4:    o_plan.bytes[j] = i_cfg.aad_len[15:8];
                                        4'd5:    o_plan.bytes[j] = i_cfg.aad_len[7:0];
                                        default: o_plan.bytes[j] = 8'd0;
                                    endcase
                                end else begin
                                    case (p)
                                        4'd0:    o_plan.bytes[j] = i_cfg.aad_len[15:8];
                                        4'd1:    o_plan.bytes[j] = i_cfg.aad_len[7:0];
                                        default: o_plan.bytes[j] = 8'd0;
                                    endcase
                                end
                            end
                        end
                    end
                    o_plan.count = {4'd0, first} + 5'd1 +
                                   (nlast ? ({1'b0, lsz} + {1'b0, plen}) : 5'd0);
                    if (nlast) begin
                        n_nonce_count = 4'd0;
                        if (aad_nz) begin
                            n_phase     = PH_AAD;
                            n_block_pos = plen;
                            n_aad_count = '0;
                        end else begin
                            n_phase           = PH_DONE;
                            o_plan.stream_end = 1'b1;
                        end
                    end else begin
                        n_nonce_count = r_nonce_count + 4'd1;
                    end
                end
                PH_AAD: begin
                    o_plan.bytes[0] = i_data_byte;
                    if (alast) begin
                        o_plan.count      = 5'd16 - {1'b0, r_block_pos};
                        o_plan.stream_end = 1'b1;
                        n_phase           = PH_DONE;
                        n_block_pos       = 4'd0;
                    end else begin
                        o_plan.count = 5'd1;
                        n_block_pos  = r_block_pos + 4'd1;
                        n_aad_count  = r_aad_count + AAD_COUNT_BITS'(1);
                    end
                end
                default: begin
                    o_plan.count = 5'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_NONCE;
            r_nonce_count <= '0;
            r_aad_count   <= '0;
            r_block_pos   <= '0;
        end else if (i_take) begin
            r_phase       <= n_phase;
            r_nonce_count <= n_nonce_count;
            r_aad_count   <= n_aad_count;
            r_block_pos   <= n_block_pos;
        end
    end

endmodule

// ===== src/ccm_header_block_formatter.sv =====
// Top level of the CCM B0 and AAD header formatter.
//
// Takes the nonce bytes and then the AAD bytes, one per request, and emits the
// CCM authentication header (B0, AAD length prefix, AAD, zero padding) one byte
// per cycle while i_out_ready is high. A request is planned in the cycle it is
// accepted and its bytes (1 to 16) are drained from the result buffer, one per
// cycle likewise; the next request is taken in the cycle the last byte of the
// current one leaves, so single-byte requests stream at one per cycle while
// i_out_ready is high. Requests after the end of the stream give no bytes. With
// an invalid nonce or payload length each request gives a single flagged zero.
// Configuration writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
module ccm_header_block_formatter import ccmf_pkg::*; #(
    parameter int AAD_COUNT_BITS = DEF_AAD_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic        o_bad_config
);

    t_cfg                      r_cfg;
    t_plan                     plan;
    logic                      r_busy;
    logic [3:0]                r_idx;
    logic [4:0]                r_cnt;
    logic [MAX_BYTES-1:0][7:0] r_buf;
    logic                      r_end;
    logic                      r_bad;
    logic                      last_out;
    logic                      take_out;
    logic                      take_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nonce_len   <= NONCE_MAX;
            r_cfg.aad_len     <= '0;
            r_cfg.payload_len <= '0;
            r_cfg.tag_len     <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NONCE_LEN:   r_cfg.nonce_len   <= i_cfg_data[3:0];
                CFG_AAD_LEN:     r_cfg.aad_len     <= i_cfg_data;
                CFG_PAYLOAD_LEN: r_cfg.payload_len <= i_cfg_data;
                CFG_TAG_LEN:     r_cfg.tag_len     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ccmf_sched #(
        .AAD_COUNT_BITS(AAD_COUNT_BITS)
    ) u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_data_byte (i_data_byte),
        .i_take      (take_in),
        .o_plan      (plan)
    );

    assign last_out   = ({1'b0, r_idx} + 5'd1) == r_cnt;
    assign take_out   = r_busy && i_out_ready;
    assign o_in_ready = !r_busy || (take_out && last_out);
    assign take_in    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take_in) begin
            r_busy <= (plan.count != 5'd0);
            r_idx  <= '0;
        end else if (take_out) begin
            if (last_out) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_buf <= plan.bytes;
            r_cnt <= plan.count;
            r_end <= plan.stream_end;
            r_bad <= plan.bad;
        end
    end

    assign o_out_valid  = r_busy;
    assign o_out_byte   = r_buf[r_idx];
    assign o_run_last   = last_out;
    assign o_stream_end = r_end && last_out;
    assign o_bad_config = r_bad;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index past result count");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_end) |-> o_run_last)
        else $error("stream end not on last byte of request");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_config) |-> (o_out_byte == 8'd0 && o_run_last))
        else $error("bad config result malformed");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> o_out_valid)
        else $error("request bytes dropped mid-run");

    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_last) |-> !o_in_ready)
        else $error("new request taken while bytes remain");

endmodule
